// File: rtl/ckey_pkg.sv
// ----------------------------------------------------------------------------
// ckey_pkg
// Shared types and constants for the color difference keyer.
// ----------------------------------------------------------------------------
package ckey_pkg;

    // Key color components and gain registers are 16 bits wide each
    localparam int KEY_W      = 16;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    // Signed width of the raw alpha sum, covers 1 + two 16-bit terms
    localparam int SUM_W = 19;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPLEMENT_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHADOW_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_HIGH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE     = 3'd6;

    // Output modes
    localparam logic [1:0] MODE_PREMULT   = 2'd0;
    localparam logic [1:0] MODE_UNPREMULT = 2'd1;
    localparam logic [1:0] MODE_ALPHA     = 2'd2;
    localparam logic [1:0] MODE_STATUS    = 2'd3;

    // Key color and gain settings as seen by the front stages
    typedef struct packed {
        logic [KEY_W-1:0] key_red;
        logic [KEY_W-1:0] key_green;
        logic [KEY_W-1:0] key_blue;
        logic [KEY_W-1:0] screen_gain;
        logic [KEY_W-1:0] complement_gain;
    } ckey_front_cfg_t;

endpackage

// File: rtl/ckey_div.sv
// ----------------------------------------------------------------------------
// ckey_div
// Pipelined restoring divider, one quotient bit per stage. Computes
// (rem << QW) / divisor for rem < divisor, carrying a payload alongside.
// ----------------------------------------------------------------------------
module ckey_div #(
    parameter int DW = 16,
    parameter int QW = 12,
    parameter int PW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [DW-1:0] in_divisor,
    input  logic [PW-1:0] in_payload,
    output logic          out_valid,
    output logic [QW-1:0] out_quotient,
    output logic [PW-1:0] out_payload
);
    logic          vld_reg [0:QW];
    logic [DW-1:0] rem_reg [0:QW];
    logic [DW-1:0] dvs_reg [0:QW];
    logic [QW-1:0] quo_reg [0:QW];
    logic [PW-1:0] pay_reg [0:QW];

    assign vld_reg[0] = in_valid;
    assign rem_reg[0] = in_rem;
    assign dvs_reg[0] = in_divisor;
    assign quo_reg[0] = '0;
    assign pay_reg[0] = in_payload;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0] trial;
        logic        take;

        // Shift in one zero bit and try the subtraction
        assign trial = {rem_reg[k], 1'b0};
        assign take  = (trial >= {1'b0, dvs_reg[k]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= take ? DW'(trial - {1'b0, dvs_reg[k]}) : trial[DW-1:0];
                dvs_reg[k+1] <= dvs_reg[k];
                quo_reg[k+1] <= {quo_reg[k][QW-2:0], take};
                pay_reg[k+1] <= pay_reg[k];
            end
        end
    end

    assign out_valid    = vld_reg[QW];
    assign out_quotient = quo_reg[QW];
    assign out_payload  = pay_reg[QW];

endmodule

// File: rtl/ckey_front.sv
// ----------------------------------------------------------------------------
// ckey_front
// Input register, screen channel selection and excess, then the screen and
// complement products summed into the signed raw alpha.
// ----------------------------------------------------------------------------
module ckey_front #(
    parameter int FRAC_BITS    = 12,
    parameter int CHANNEL_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  ckey_pkg::ckey_front_cfg_t     cfg,
    input  logic                          in_valid,
    input  logic [CHANNEL_BITS-1:0]       in_red,
    input  logic [CHANNEL_BITS-1:0]       in_green,
    input  logic [CHANNEL_BITS-1:0]       in_blue,
    input  logic [FRAC_BITS:0]            in_mask,
    output logic                          out_valid,
    output logic signed [ckey_pkg::SUM_W-1:0] out_sum,
    output logic [CHANNEL_BITS-1:0]       out_red,
    output logic [CHANNEL_BITS-1:0]       out_green,
    output logic [CHANNEL_BITS-1:0]       out_blue,
    output logic [FRAC_BITS:0]            out_mask,
    output logic                          out_shadow_en,
    output logic [ckey_pkg::KEY_W-1:0]    out_scr,
    output logic [ckey_pkg::KEY_W-1:0]    out_kscr
);
    import ckey_pkg::*;

    localparam int W0 = (CHANNEL_BITS > KEY_W) ? CHANNEL_BITS : KEY_W;
    localparam int XW = (W0 > FRAC_BITS + 2) ? W0 : FRAC_BITS + 2;
    localparam int AW = FRAC_BITS + 1;
    localparam int PW = KEY_W + AW;
    localparam logic [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;
    localparam logic [AW-1:0] ONE_A = AW'(1) << FRAC_BITS;

    // Stage A: input register, saturate mask
    logic                    a_valid_reg;
    logic [CHANNEL_BITS-1:0] a_red_reg, a_green_reg, a_blue_reg;
    logic [AW-1:0]           a_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_red_reg   <= in_red;
            a_green_reg <= in_green;
            a_blue_reg  <= in_blue;
            a_mask_reg  <= (in_mask > ONE_A) ? ONE_A : in_mask;
        end
    end

    // Stage B: pick screen channel, clamp, excess over key
    logic          green_screen;
    logic [XW-1:0] scr_x, oth_x, kscr_x, koth_x, red_x, kred_x;
    logic [XW-1:0] diff_r, diff_o, ex_r, ex_o, ex_x, sat_x;

    always_comb begin
        green_screen = (cfg.key_green > cfg.key_blue);
        scr_x  = green_screen ? XW'(a_green_reg) : XW'(a_blue_reg);
        oth_x  = green_screen ? XW'(a_blue_reg) : XW'(a_green_reg);
        kscr_x = green_screen ? XW'(cfg.key_green) : XW'(cfg.key_blue);
        koth_x = green_screen ? XW'(cfg.key_blue) : XW'(cfg.key_green);
        red_x  = XW'(a_red_reg);
        kred_x = XW'(cfg.key_red);
        diff_r = red_x - kred_x;
        diff_o = oth_x - koth_x;
        ex_r   = (red_x > kred_x) ? ((diff_r > ONE_X) ? ONE_X : diff_r) : '0;
        ex_o   = (oth_x > koth_x) ? ((diff_o > ONE_X) ? ONE_X : diff_o) : '0;
        ex_x   = (ex_r > ex_o) ? ex_r : ex_o;
        sat_x  = (scr_x > ONE_X) ? ONE_X : scr_x;
    end

    logic                    b_valid_reg;
    logic [CHANNEL_BITS-1:0] b_red_reg, b_green_reg, b_blue_reg;
    logic [AW-1:0]           b_mask_reg, b_sat_reg, b_ex_reg;
    logic                    b_shadow_reg;
    logic [KEY_W-1:0]        b_scr_reg, b_kscr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_red_reg    <= a_red_reg;
            b_green_reg  <= a_green_reg;
            b_blue_reg   <= a_blue_reg;
            b_mask_reg   <= a_mask_reg;
            b_sat_reg    <= sat_x[AW-1:0];
            b_ex_reg     <= ex_x[AW-1:0];
            b_shadow_reg <= (kscr_x != '0) && (scr_x < kscr_x);
            b_scr_reg    <= scr_x[KEY_W-1:0];
            b_kscr_reg   <= kscr_x[KEY_W-1:0];
        end
    end

    // Stage C: screen and complement products into the signed sum
    logic [PW-1:0]           prod_scr, prod_cmp;
    logic signed [SUM_W-1:0] sum_next;

    always_comb begin
        prod_scr = PW'(cfg.screen_gain) * PW'(b_sat_reg);
        prod_cmp = PW'(cfg.complement_gain) * PW'(b_ex_reg);
        sum_next = SUM_W'(ONE_X) - SUM_W'(prod_scr >> FRAC_BITS)
                 + SUM_W'(prod_cmp >> FRAC_BITS);
    end

    logic                    c_valid_reg;
    logic signed [SUM_W-1:0] c_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_sum_reg     <= sum_next;
            out_red       <= b_red_reg;
            out_green     <= b_green_reg;
            out_blue      <= b_blue_reg;
            out_mask      <= b_mask_reg;
            out_shadow_en <= b_shadow_reg;
            out_scr       <= b_scr_reg;
            out_kscr      <= b_kscr_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_sum   = c_sum_reg;

endmodule

// File: rtl/ckey_out.sv
// ----------------------------------------------------------------------------
// ckey_out
// Remapped alpha times mask, then output mode selection and premultiply
// into the result register.
// ----------------------------------------------------------------------------
module ckey_out #(
    parameter int FRAC_BITS    = 12,
    parameter int CHANNEL_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic [1:0]              output_mode,
    input  logic                    in_valid,
    input  logic                    in_zero,
    input  logic                    in_one,
    input  logic [FRAC_BITS-1:0]    in_quotient,
    input  logic [CHANNEL_BITS-1:0] in_red,
    input  logic [CHANNEL_BITS-1:0] in_green,
    input  logic [CHANNEL_BITS-1:0] in_blue,
    input  logic [FRAC_BITS:0]      in_mask,
    output logic                    out_valid,
    output logic [CHANNEL_BITS-1:0] out_red,
    output logic [CHANNEL_BITS-1:0] out_green,
    output logic [CHANNEL_BITS-1:0] out_blue,
    output logic [FRAC_BITS:0]      out_alpha
);
    import ckey_pkg::*;

    localparam int AW = FRAC_BITS + 1;
    localparam int MW = 2 * AW;
    localparam int CW = CHANNEL_BITS + AW;
    localparam logic [AW-1:0] ONE_A  = AW'(1) << FRAC_BITS;
    localparam logic [AW-1:0] HALF_A = AW'(1) << (FRAC_BITS - 1);

    // Stage F: pick remapped alpha and apply mask
    logic [AW-1:0] remap_a;
    logic [MW-1:0] masked;

    always_comb begin
        remap_a = in_zero ? '0 : (in_one ? ONE_A : {1'b0, in_quotient});
        masked  = MW'(remap_a) * MW'(in_mask);
    end

    logic                    f_valid_reg;
    logic [AW-1:0]           f_alpha_reg;
    logic [CHANNEL_BITS-1:0] f_red_reg, f_green_reg, f_blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_alpha_reg <= AW'(masked >> FRAC_BITS);
            f_red_reg   <= in_red;
            f_green_reg <= in_green;
            f_blue_reg  <= in_blue;
        end
    end

    // Stage G: output mode and premultiply
    logic [CW-1:0]           prod_r, prod_g, prod_b;
    logic [AW-1:0]           alpha_sel;
    logic [CHANNEL_BITS-1:0] red_next, green_next, blue_next;

    always_comb begin
        prod_r    = CW'(f_red_reg) * CW'(f_alpha_reg);
        prod_g    = CW'(f_green_reg) * CW'(f_alpha_reg);
        prod_b    = CW'(f_blue_reg) * CW'(f_alpha_reg);
        alpha_sel = f_alpha_reg;
        if (output_mode == MODE_STATUS && f_alpha_reg != '0 && f_alpha_reg < ONE_A) begin
            alpha_sel = HALF_A;
        end
        case (output_mode)
            MODE_PREMULT: begin
                red_next   = CHANNEL_BITS'(prod_r >> FRAC_BITS);
                green_next = CHANNEL_BITS'(prod_g >> FRAC_BITS);
                blue_next  = CHANNEL_BITS'(prod_b >> FRAC_BITS);
            end
            MODE_UNPREMULT: begin
                red_next   = f_red_reg;
                green_next = f_green_reg;
                blue_next  = f_blue_reg;
            end
            default: begin
                red_next   = CHANNEL_BITS'(alpha_sel);
                green_next = CHANNEL_BITS'(alpha_sel);
                blue_next  = CHANNEL_BITS'(alpha_sel);
            end
        endcase
    end

    logic g_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (en) begin
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_red   <= red_next;
            out_green <= green_next;
            out_blue  <= blue_next;
            out_alpha <= alpha_sel;
        end
    end

    assign out_valid = g_valid_reg;

endmodule

// File: rtl/color_difference_keyer.sv
// ----------------------------------------------------------------------------
// color_difference_keyer
// Color difference chroma keyer: RGB pixel plus mask alpha in, keyed pixel
// and alpha out, unsigned fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one pixel per transaction (red, green, blue, mask alpha),
//   m_* returns one keyed pixel per transaction in the same order.
//   cfg_* writes one setting register per transaction; cfg_ready is always
//   high. Write settings only while no pixel is in flight.
// Pipeline: 2 * FRAC_BITS + 6 register stages (three front stages, two
//   pipelined dividers of FRAC_BITS stages each for the shadow ratio and
//   the threshold remap, shadow stage, mask stage and output register).
// Throughput: one pixel per clock while m_tready is high.
// Stall: with m_tvalid high and m_tready low the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
// Reset: aresetn low empties the pipeline and loads the default key
//   (pure blue), unit gains, no shadow, thresholds 0 and 1, premultiplied.
// ----------------------------------------------------------------------------
module color_difference_keyer #(
    parameter int FRAC_BITS    = 12,
    parameter int CHANNEL_BITS = 16,
    localparam int ITEM_W  = 3 * CHANNEL_BITS + FRAC_BITS + 1,
    localparam int TDATA_W = ((ITEM_W + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Pixel in: in_red, in_green, in_blue, mask_alpha (lowest first)
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [TDATA_W-1:0]                s_tdata,
    // Pixel out: out_red, out_green, out_blue, out_alpha (lowest first)
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [TDATA_W-1:0]                m_tdata,
    // Setting register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ckey_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ckey_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ckey_pkg::*;

    localparam int AW  = FRAC_BITS + 1;
    localparam int SPW = KEY_W + AW;
    localparam int P1W = SUM_W + 3 * CHANNEL_BITS + AW + 1;
    localparam int P2W = 2 + 3 * CHANNEL_BITS + AW;
    localparam logic [AW-1:0] ONE_A  = AW'(1) << FRAC_BITS;
    localparam logic [AW-1:0] HALF_A = AW'(1) << (FRAC_BITS - 1);

    // Setting registers
    logic [CFG_DATA_W-1:0] key_reg;
    logic [KEY_W-1:0]      screen_gain_reg, complement_gain_reg, shadow_gain_reg;
    logic [AW-1:0]         thresh_low_reg, thresh_high_reg;
    logic [1:0]            mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg             <= CFG_DATA_W'(4096);
            screen_gain_reg     <= KEY_W'(4096);
            complement_gain_reg <= KEY_W'(4096);
            shadow_gain_reg     <= '0;
            thresh_low_reg      <= '0;
            thresh_high_reg     <= AW'(4096);
            mode_reg            <= MODE_PREMULT;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY_COLOR:       key_reg             <= cfg_data;
                REG_SCREEN_GAIN:     screen_gain_reg     <= cfg_data[KEY_W-1:0];
                REG_COMPLEMENT_GAIN: complement_gain_reg <= cfg_data[KEY_W-1:0];
                REG_SHADOW_GAIN:     shadow_gain_reg     <= cfg_data[KEY_W-1:0];
                REG_THRESH_LOW:      thresh_low_reg      <= cfg_data[AW-1:0];
                REG_THRESH_HIGH:     thresh_high_reg     <= cfg_data[AW-1:0];
                REG_OUTPUT_MODE:     mode_reg            <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    ckey_front_cfg_t front_cfg;

    assign front_cfg.key_red         = key_reg[3*KEY_W-1:2*KEY_W];
    assign front_cfg.key_green       = key_reg[2*KEY_W-1:KEY_W];
    assign front_cfg.key_blue        = key_reg[KEY_W-1:0];
    assign front_cfg.screen_gain     = screen_gain_reg;
    assign front_cfg.complement_gain = complement_gain_reg;

    // Whole pipeline advances unless the result register is held
    logic en;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Front stages
    logic                    c_valid, c_shadow_en;
    logic signed [SUM_W-1:0] c_sum;
    logic [CHANNEL_BITS-1:0] c_red, c_green, c_blue;
    logic [AW-1:0]           c_mask;
    logic [KEY_W-1:0]        c_scr, c_kscr;

    ckey_front #(
        .FRAC_BITS    (FRAC_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .cfg           (front_cfg),
        .in_valid      (s_tvalid),
        .in_red        (s_tdata[CHANNEL_BITS-1:0]),
        .in_green      (s_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
        .in_blue       (s_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
        .in_mask       (s_tdata[ITEM_W-1:3*CHANNEL_BITS]),
        .out_valid     (c_valid),
        .out_sum       (c_sum),
        .out_red       (c_red),
        .out_green     (c_green),
        .out_blue      (c_blue),
        .out_mask      (c_mask),
        .out_shadow_en (c_shadow_en),
        .out_scr       (c_scr),
        .out_kscr      (c_kscr)
    );

    // Shadow ratio divider
    logic                 r_valid;
    logic [FRAC_BITS-1:0] ratio;
    logic [P1W-1:0]       r_pay;

    ckey_div #(
        .DW (KEY_W),
        .QW (FRAC_BITS),
        .PW (P1W)
    ) u_ratio_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (c_valid),
        .in_rem       (c_scr),
        .in_divisor   (c_kscr),
        .in_payload   ({c_sum, c_red, c_green, c_blue, c_mask, c_shadow_en}),
        .out_valid    (r_valid),
        .out_quotient (ratio),
        .out_payload  (r_pay)
    );

    logic signed [SUM_W-1:0] r_sum;
    logic [CHANNEL_BITS-1:0] r_red, r_green, r_blue;
    logic [AW-1:0]           r_mask;
    logic                    r_shadow_en;

    assign {r_sum, r_red, r_green, r_blue, r_mask, r_shadow_en} = r_pay;

    // Shadow stage: add shadow term
    logic [SPW-1:0]          prod_shadow;
    logic signed [SUM_W-1:0] sum_next;

    always_comb begin
        prod_shadow = SPW'(shadow_gain_reg) * SPW'(ONE_A - {1'b0, ratio});
        sum_next    = r_shadow_en ? r_sum + SUM_W'(prod_shadow >> FRAC_BITS) : r_sum;
    end

    logic                    d_valid_reg;
    logic signed [SUM_W-1:0] d_sum_reg;
    logic [CHANNEL_BITS-1:0] d_red_reg, d_green_reg, d_blue_reg;
    logic [AW-1:0]           d_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_sum_reg   <= sum_next;
            d_red_reg   <= r_red;
            d_green_reg <= r_green;
            d_blue_reg  <= r_blue;
            d_mask_reg  <= r_mask;
        end
    end

    // Threshold classify, feeding the remap divider
    logic signed [SUM_W-1:0] low_s, high_s, diff_s;
    logic                    is_zero, is_one;
    logic [AW-1:0]           span;

    always_comb begin
        low_s   = SUM_W'(thresh_low_reg);
        high_s  = SUM_W'(thresh_high_reg);
        is_zero = (d_sum_reg <= low_s);
        is_one  = (d_sum_reg >= high_s) || (thresh_high_reg == thresh_low_reg);
        diff_s  = d_sum_reg - low_s;
        span    = thresh_high_reg - thresh_low_reg;
    end

    logic                 q_valid;
    logic [FRAC_BITS-1:0] remap_q;
    logic [P2W-1:0]       q_pay;

    ckey_div #(
        .DW (AW),
        .QW (FRAC_BITS),
        .PW (P2W)
    ) u_remap_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (d_valid_reg),
        .in_rem       (diff_s[AW-1:0]),
        .in_divisor   (span),
        .in_payload   ({is_zero, is_one, d_red_reg, d_green_reg, d_blue_reg, d_mask_reg}),
        .out_valid    (q_valid),
        .out_quotient (remap_q),
        .out_payload  (q_pay)
    );

    logic                    q_zero, q_one;
    logic [CHANNEL_BITS-1:0] q_red, q_green, q_blue;
    logic [AW-1:0]           q_mask;

    assign {q_zero, q_one, q_red, q_green, q_blue, q_mask} = q_pay;

    // Mask and output stages
    logic [CHANNEL_BITS-1:0] o_red, o_green, o_blue;
    logic [AW-1:0]           o_alpha;

    ckey_out #(
        .FRAC_BITS    (FRAC_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .output_mode (mode_reg),
        .in_valid    (q_valid),
        .in_zero     (q_zero),
        .in_one      (q_one),
        .in_quotient (remap_q),
        .in_red      (q_red),
        .in_green    (q_green),
        .in_blue     (q_blue),
        .in_mask     (q_mask),
        .out_valid   (m_tvalid),
        .out_red     (o_red),
        .out_green   (o_green),
        .out_blue    (o_blue),
        .out_alpha   (o_alpha)
    );

    assign m_tdata = TDATA_W'({o_alpha, o_blue, o_green, o_red});

    // Final alpha never exceeds one
    a_alpha_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (o_alpha <= ONE_A))
        else $error("out_alpha above one");

    // Status mode only yields zero, one half or one
    a_status_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && mode_reg == MODE_STATUS) |->
            (o_alpha == '0 || o_alpha == HALF_A || o_alpha == ONE_A))
        else $error("status alpha not 0, 1/2 or 1");

    // Pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

// File: tb/color_difference_keyer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_difference_keyer_tb
// Streams pixels through the keyer under several register settings and
// checks every keyed pixel against a predictor of the fixed point math,
// with random source gaps and sink backpressure in three idling phases.
// ----------------------------------------------------------------------------
module color_difference_keyer_tb;
    import ckey_pkg::*;

    localparam int FRAC     = 12;
    localparam int TDATA_W  = 64;
    localparam int LATENCY  = 2 * FRAC + 6;
    localparam logic [63:0] ONE = 64'd4096;

    typedef struct packed {
        logic [12:0] alpha;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } pixel_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    color_difference_keyer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of the setting registers
    logic [47:0] key_color;
    logic [15:0] screen_gain, complement_gain, shadow_gain;
    logic [12:0] thresh_low, thresh_high;
    logic [1:0]  output_mode;

    pixel_t pending_pixels[$];
    pixel_t expected_pixels[$];
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int errors = 0;

    function automatic logic [63:0] clamp_one(logic [63:0] v);
        return v > ONE ? ONE : v;
    endfunction

    function automatic logic [63:0] excess_over(logic [63:0] v, logic [63:0] k);
        return v > k ? clamp_one(v - k) : 64'd0;
    endfunction

    function automatic pixel_t key_pixel(pixel_t px);
        logic [63:0] r, g, b, m, kr, kg, kb, scr, oth, kscr, koth, ex, a, ratio;
        longint sum;
        pixel_t res;
        r = px.red; g = px.green; b = px.blue;
        m = clamp_one(64'(px.alpha));
        kr = key_color[47:32]; kg = key_color[31:16]; kb = key_color[15:0];
        if (kg > kb) begin
            scr = g; oth = b; kscr = kg; koth = kb;
        end else begin
            scr = b; oth = g; kscr = kb; koth = kg;
        end
        sum = longint'(ONE) - longint'((64'(screen_gain) * clamp_one(scr)) >> FRAC);
        ex = excess_over(r, kr);
        if (excess_over(oth, koth) > ex) ex = excess_over(oth, koth);
        sum += longint'((64'(complement_gain) * ex) >> FRAC);
        if (kscr != 0 && scr < kscr) begin
            ratio = (scr << FRAC) / kscr;
            sum += longint'((64'(shadow_gain) * (ONE - ratio)) >> FRAC);
        end
        // Threshold remap
        if (sum <= longint'(thresh_low)) a = 0;
        else if (sum >= longint'(thresh_high) || thresh_high == thresh_low) a = ONE;
        else a = ((64'(sum) - thresh_low) << FRAC) / (64'(thresh_high) - thresh_low);
        a = (a * m) >> FRAC;
        case (output_mode)
            MODE_PREMULT: begin
                res.red = 16'((r * a) >> FRAC);
                res.green = 16'((g * a) >> FRAC);
                res.blue = 16'((b * a) >> FRAC);
            end
            MODE_UNPREMULT: begin
                res.red = r[15:0]; res.green = g[15:0]; res.blue = b[15:0];
            end
            default: begin
                if (output_mode == MODE_STATUS && a > 0 && a < ONE) a = ONE >> 1;
                res.red = a[15:0]; res.green = a[15:0]; res.blue = a[15:0];
            end
        endcase
        res.alpha = a[12:0];
        return res;
    endfunction

    // Drive pixels from the pending queue
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_pixels.push_back(key_pixel(pixel_t'(s_tdata[60:0])));
                void'(pending_pixels.pop_front());
            end
            if ((!s_tvalid || s_tready) ) begin
                if ((s_tvalid && s_tready ? pending_pixels.size() > 0
                                          : pending_pixels.size() > 0)
                    && $urandom_range(99) >= src_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {3'b0, pending_pixels[0]};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check keyed pixels and toggle backpressure
    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = pixel_t'(m_tdata[60:0]);
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel %h", got);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.red !== want.red) begin
                        $error("out_red exp %h got %h", want.red, got.red); errors++;
                    end
                    if (got.green !== want.green) begin
                        $error("out_green exp %h got %h", want.green, got.green); errors++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("out_blue exp %h got %h", want.blue, got.blue); errors++;
                    end
                    if (got.alpha !== want.alpha) begin
                        $error("out_alpha exp %h got %h", want.alpha, got.alpha); errors++;
                    end
                end
            end
            m_tready <= $urandom_range(99) >= snk_idle_pct;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_KEY_COLOR:       key_color = val;
            REG_SCREEN_GAIN:     screen_gain = val[15:0];
            REG_COMPLEMENT_GAIN: complement_gain = val[15:0];
            REG_SHADOW_GAIN:     shadow_gain = val[15:0];
            REG_THRESH_LOW:      thresh_low = val[12:0];
            REG_THRESH_HIGH:     thresh_high = val[12:0];
            REG_OUTPUT_MODE:     output_mode = val[1:0];
            default: ;
        endcase
    endtask

    // Hold until every pixel has come back and the pipeline is empty
    task automatic drain();
        while (pending_pixels.size() > 0 || s_tvalid || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(5))
            0: return 16'($urandom_range(4096));
            1: return 16'($urandom);
            2: return 16'hFFFF;
            3: return 16'd0;
            default: return 16'($urandom_range(5000));
        endcase
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'd40960;
            default: return 16'($urandom_range(40960));
        endcase
    endfunction

    task automatic push_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                              logic [12:0] m);
        pixel_t px;
        px.red = r; px.green = g; px.blue = b; px.alpha = m;
        pending_pixels.push_back(px);
    endtask

    task automatic random_settings();
        logic [15:0] k0, k1;
        k0 = 16'($urandom_range(4096));
        k1 = 16'($urandom_range(1500));
        // Pick green or blue screen, sometimes zero key screen
        case ($urandom_range(3))
            0: write_reg(REG_KEY_COLOR, {16'($urandom_range(2000)), k0, k1});
            1: write_reg(REG_KEY_COLOR, {16'($urandom_range(2000)), k1, k0});
            2: write_reg(REG_KEY_COLOR, {16'($urandom), 16'd0, 16'd0});
            default: write_reg(REG_KEY_COLOR, 48'($urandom) ^ {$urandom, 16'h0});
        endcase
        write_reg(REG_SCREEN_GAIN, rand_gain());
        write_reg(REG_COMPLEMENT_GAIN, rand_gain());
        write_reg(REG_SHADOW_GAIN, rand_gain());
        write_reg(REG_THRESH_LOW, 48'($urandom_range(4096)));
        write_reg(REG_THRESH_HIGH, 48'($urandom_range(4096)));
        write_reg(REG_OUTPUT_MODE, 48'($urandom_range(3)));
    endtask

    initial begin
        key_color = 48'd4096; screen_gain = 16'd4096; complement_gain = 16'd4096;
        shadow_gain = 16'd0; thresh_low = 13'd0; thresh_high = 13'd4096;
        output_mode = MODE_PREMULT;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings, then extremes of every mode and threshold
        write_reg(REG_KEY_COLOR, {16'd200, 16'd3800, 16'd400});
        write_reg(REG_SHADOW_GAIN, 48'd8192);
        write_reg(REG_THRESH_LOW, 48'd512);
        write_reg(REG_THRESH_HIGH, 48'd3584);
        for (int md = 0; md < 4; md++) begin
            write_reg(REG_OUTPUT_MODE, 48'(md));
            push_pixel(16'd0, 16'd0, 16'd0, 13'd4096);
            push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 13'h1FFF);
            push_pixel(16'd1000, 16'd3000, 16'd500, 13'd2048);
            push_pixel(16'd4000, 16'd1900, 16'd4096, 13'd0);
            push_pixel(16'd300, 16'd3700, 16'd300, 13'd4097);
            drain();
        end
        // Low above high, equal thresholds, zero key screen, max gains
        write_reg(REG_THRESH_LOW, 48'd3000);
        write_reg(REG_THRESH_HIGH, 48'd1000);
        push_pixel(16'd2000, 16'd1000, 16'd2000, 13'd4096);
        push_pixel(16'd100, 16'd2500, 16'd100, 13'd4096);
        drain();
        write_reg(REG_THRESH_HIGH, 48'd3000);
        write_reg(REG_KEY_COLOR, {16'hFFFF, 16'd0, 16'd0});
        write_reg(REG_SCREEN_GAIN, 48'd40960);
        write_reg(REG_COMPLEMENT_GAIN, 48'd40960);
        write_reg(REG_SHADOW_GAIN, 48'd40960);
        push_pixel(16'd0, 16'd0, 16'd3000, 13'd4096);
        push_pixel(16'd0, 16'd9000, 16'd0, 13'd4096);
        push_pixel(16'd0, 16'd0, 16'd0, 13'd1234);
        drain();

        // Random: three idling phases, new settings every 45 pixels
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 58 : 0;
            snk_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 11 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                random_settings();
                for (int i = 0; i < 45; i++)
                    push_pixel(rand_chan(), rand_chan(), rand_chan(),
                               ($urandom_range(7) == 0) ? 13'($urandom)
                                                        : 13'($urandom_range(4096)));
                drain();
            end
        end
        snk_idle_pct = 0;
        drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: sim.f
rtl/ckey_pkg.sv
rtl/ckey_div.sv
rtl/ckey_front.sv
rtl/ckey_out.sv
rtl/color_difference_keyer.sv
tb/color_difference_keyer_tb.sv
